// ===== rtl/integer_matrix_multiply_macros.svh =====
// Assertion macros shared by the integer matrix multiply RTL.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define IMM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen on a rising clk edge outside reset.
`define IMM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define IMM_ASSERT(lbl, prop, msg)
`define IMM_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/imm_pkg.sv =====
// Shared constants, types and helpers of the integer matrix multiply.
`timescale 1ns / 1ps
package imm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int ELEM_W      = 32;
	localparam int DIM_W       = $clog2(MAX_DIM + 1);
	localparam int IDX_W       = $clog2(MAX_DIM);
	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = $clog2(2 * STORE_DEPTH);
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = CFG_IDX_W'(2);

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

	// matrix sizes, already clamped to 1..MAX_DIM
	typedef struct packed {
		logic [DIM_W-1:0] m;
		logic [DIM_W-1:0] n;
		logic [DIM_W-1:0] k;
	} dims_t;

	// one A element travelling along the cell row
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  t;
		logic              last;
		logic [ELEM_W-1:0] data;
	} feed_t;

	// B element write into one cell's column slots
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  slot;
		logic [ELEM_W-1:0] data;
	} bwr_t;

	// zero counts as one, anything above MAX_DIM as MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > CFG_DATA_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/imm_cell.sv =====
// One multiply-accumulate cell: holds a column of B and builds one C element per row.
`timescale 1ns / 1ps
module imm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [imm_pkg::IDX_W-1:0]    col_id,
	input  imm_pkg::bwr_t                bwr,
	input  imm_pkg::feed_t               feed_in,
	output imm_pkg::feed_t               feed_out,
	output logic                         done,
	output logic [imm_pkg::ELEM_W-1:0]   acc
);

	logic [imm_pkg::ELEM_W-1:0] b_q [imm_pkg::MAX_DIM];

	logic                       fv_q;
	logic [imm_pkg::IDX_W-1:0]  ft_q;
	logic                       fl_q;
	logic [imm_pkg::ELEM_W-1:0] fd_q;

	logic                       v_s1;
	logic                       first_s1;
	logic                       last_s1;
	logic [imm_pkg::ELEM_W-1:0] prod_s1;

	logic                       done_q;
	logic [imm_pkg::ELEM_W-1:0] acc_q;

	// column slots of B, filled while the matrices load
	always_ff @(posedge clk) begin
		if (bwr.we && bwr.col == col_id) begin
			b_q[bwr.slot] <= bwr.data;
		end
	end

	// hand the A element on to the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else begin
			fv_q <= feed_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		ft_q <= feed_in.t;
		fl_q <= feed_in.last;
		fd_q <= feed_in.data;
	end

	assign feed_out = '{valid: fv_q, t: ft_q, last: fl_q, data: fd_q};

	// multiply stage, low word only: wraps as the accumulator does
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= feed_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= feed_in.data * b_q[feed_in.t];
		first_s1 <= (feed_in.t == '0);
		last_s1  <= feed_in.last;
	end

	// accumulate; restart on the first term of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= first_s1 ? prod_s1 : acc_q + prod_s1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ===== rtl/imm_ctrl.sv =====
// Load sequencer, A store and row feeder for the cell row.
`timescale 1ns / 1ps
module imm_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [imm_pkg::ELEM_W-1:0]  element,
	input  logic                               cfg_clear,
	input  imm_pkg::dims_t                     dims,
	input  logic                               res_last,
	output logic                               busy,
	output imm_pkg::bwr_t                      bwr,
	output imm_pkg::feed_t                     feed
);

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_FEED  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0] state_q;

	logic [imm_pkg::ELEM_W-1:0] a_mem [imm_pkg::STORE_DEPTH];

	logic [imm_pkg::POS_W-1:0]  pos_q;
	logic [imm_pkg::IDX_W-1:0]  bt_q;
	logic [imm_pkg::IDX_W-1:0]  bj_q;
	logic [imm_pkg::IDX_W-1:0]  fi_q;
	logic [imm_pkg::IDX_W-1:0]  fp_q;
	logic [imm_pkg::ADDR_W-1:0] base_q;

	logic                       fv_q;
	logic [imm_pkg::IDX_W-1:0]  ft_q;
	logic                       fl_q;
	logic [imm_pkg::ELEM_W-1:0] rd_q;

	logic                       accept;
	logic [imm_pkg::POS_W-1:0]  m_w;
	logic [imm_pkg::POS_W-1:0]  n_w;
	logic [imm_pkg::POS_W-1:0]  k_w;
	logic [imm_pkg::POS_W-1:0]  a_len;
	logic [imm_pkg::POS_W-1:0]  b_len;
	logic [imm_pkg::POS_W:0]    total;
	logic [imm_pkg::POS_W:0]    pos_inc;
	logic                       at_end;
	logic                       in_a;
	logic                       bj_wrap;
	logic [imm_pkg::DIM_W-1:0]  span;
	logic                       issue;
	logic                       fp_wrap;
	logic                       fi_wrap;
	logic                       fp_last;
	logic [imm_pkg::ADDR_W-1:0] rd_addr;

	// load bookkeeping
	assign accept  = start && state_q == ST_LOAD;
	assign m_w     = imm_pkg::POS_W'(dims.m);
	assign n_w     = imm_pkg::POS_W'(dims.n);
	assign k_w     = imm_pkg::POS_W'(dims.k);
	assign a_len   = m_w * k_w;
	assign b_len   = k_w * n_w;
	assign total   = {1'b0, a_len} + {1'b0, b_len};
	assign pos_inc = {1'b0, pos_q} + {{imm_pkg::POS_W{1'b0}}, 1'b1};
	assign at_end  = pos_inc == total;
	assign in_a    = pos_q < a_len;
	assign bj_wrap = imm_pkg::DIM_W'(bj_q) + imm_pkg::DIM_W'(1) == dims.n;

	// feed pacing: the row position runs up to max(K, N), issuing A elements only below K
	assign span    = (dims.k > dims.n) ? dims.k : dims.n;
	assign issue   = state_q == ST_FEED && imm_pkg::DIM_W'(fp_q) < dims.k;
	assign fp_wrap = imm_pkg::DIM_W'(fp_q) + imm_pkg::DIM_W'(1) == span;
	assign fi_wrap = imm_pkg::DIM_W'(fi_q) + imm_pkg::DIM_W'(1) == dims.m;
	assign fp_last = imm_pkg::DIM_W'(fp_q) + imm_pkg::DIM_W'(1) == dims.k;
	assign rd_addr = base_q + imm_pkg::ADDR_W'(fp_q);

	// B elements go straight to the cell of their column
	assign bwr = '{we: accept && !in_a, col: bj_q, slot: bt_q, data: element};

	assign busy = state_q != ST_LOAD;

	// A store
	always_ff @(posedge clk) begin
		if (accept && in_a) begin
			a_mem[pos_q[imm_pkg::ADDR_W-1:0]] <= element;
		end
		rd_q <= a_mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q   <= '0;
			bt_q    <= '0;
			bj_q    <= '0;
			fi_q    <= '0;
			fp_q    <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (cfg_clear) begin
						pos_q <= '0;
						bt_q  <= '0;
						bj_q  <= '0;
					end else if (accept) begin
						if (!in_a) begin
							if (bj_wrap) begin
								bj_q <= '0;
								bt_q <= bt_q + imm_pkg::IDX_W'(1);
							end else begin
								bj_q <= bj_q + imm_pkg::IDX_W'(1);
							end
						end
						if (at_end) begin
							pos_q   <= '0;
							bt_q    <= '0;
							bj_q    <= '0;
							state_q <= ST_FEED;
						end else begin
							pos_q <= pos_inc[imm_pkg::POS_W-1:0];
						end
					end
				end
				ST_FEED: begin
					if (fp_wrap) begin
						fp_q <= '0;
						if (fi_wrap) begin
							fi_q    <= '0;
							base_q  <= '0;
							state_q <= ST_DRAIN;
						end else begin
							fi_q   <= fi_q + imm_pkg::IDX_W'(1);
							base_q <= base_q + imm_pkg::ADDR_W'(dims.k);
						end
					end else begin
						fp_q <= fp_q + imm_pkg::IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (res_last) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// feed beat to the first cell, aligned with the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= 1'b0;
		end else begin
			fv_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		ft_q <= fp_q;
		fl_q <= fp_last;
	end

	assign feed = '{valid: fv_q, t: ft_q, last: fl_q, data: rd_q};

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiply: configuration, cell row and result port.
//
// Use: set row_count (M), col_count (N) and inner_count (K) through the write port
// (cfg_write, cfg_index, cfg_data) while idle; 0 counts as 1, above 8 as 8. Each write
// to a known index restarts the load. Then give one element per beat on start/element
// while busy is low: the M*K elements of A row-major, then the K*N elements of B
// row-major, one beat per cycle at most.
// The beat that carries the last B element raises busy. A is read from the A store one
// row at a time and passed along a row of eight MAC cells, each holding one column of B.
// Each row of A leaves the single A store read port through its read register; each C
// element then passes the multiply and accumulate registers of its cell and the result
// register on its way to the port. Row spacing is set by max(K,N) in the feeder.
// Results come row-major, one per cycle within a row, each marked by result_strobe for
// one cycle with row_index, col_index and last; the receiver cannot stall them.
// busy falls after the beat flagged last and the next pair of matrices may load.
// Reset (arst_n low) sets all three sizes to 8, clears the load position and drops
// any work in progress.
`timescale 1ns / 1ps
`include "integer_matrix_multiply_macros.svh"
module integer_matrix_multiply (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [imm_pkg::ELEM_W-1:0]    element,
	output logic                                 busy,
	input  logic                                 cfg_write,
	input  logic [imm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [imm_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 result_strobe,
	output logic signed [imm_pkg::ELEM_W-1:0]    c_element,
	output logic [imm_pkg::IDX_W-1:0]            row_index,
	output logic [imm_pkg::IDX_W-1:0]            col_index,
	output logic                                 last
);

	logic [imm_pkg::DIM_W-1:0] m_q;
	logic [imm_pkg::DIM_W-1:0] n_q;
	logic [imm_pkg::DIM_W-1:0] k_q;
	logic                      cfg_clear;
	imm_pkg::dims_t            dims;

	imm_pkg::bwr_t             bwr;
	imm_pkg::feed_t            chain [imm_pkg::MAX_DIM+1];
	logic [imm_pkg::MAX_DIM-1:0] done_vec;
	logic [imm_pkg::MAX_DIM-1:0] col_mask;
	logic [imm_pkg::ELEM_W-1:0]  acc_arr [imm_pkg::MAX_DIM];

	logic                       hit;
	logic [imm_pkg::ELEM_W-1:0] sel;
	logic                       res_v_q;
	logic [imm_pkg::ELEM_W-1:0] res_d_q;
	logic [imm_pkg::IDX_W-1:0]  out_row_q;
	logic [imm_pkg::IDX_W-1:0]  out_col_q;
	logic                       row_wrap;
	logic                       col_wrap;

	// configuration registers
	assign cfg_clear = cfg_write && (cfg_index == imm_pkg::REG_ROW_COUNT ||
		cfg_index == imm_pkg::REG_COL_COUNT || cfg_index == imm_pkg::REG_INNER_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= imm_pkg::DIM_RESET;
			n_q <= imm_pkg::DIM_RESET;
			k_q <= imm_pkg::DIM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				imm_pkg::REG_ROW_COUNT:   m_q <= imm_pkg::clamp_dim(cfg_data);
				imm_pkg::REG_COL_COUNT:   n_q <= imm_pkg::clamp_dim(cfg_data);
				imm_pkg::REG_INNER_COUNT: k_q <= imm_pkg::clamp_dim(cfg_data);
				default: ;
			endcase
		end
	end

	assign dims = '{m: m_q, n: n_q, k: k_q};

	// loader and row feeder
	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.element   (element),
		.cfg_clear (cfg_clear),
		.dims      (dims),
		.res_last  (last),
		.busy      (busy),
		.bwr       (bwr),
		.feed      (chain[0])
	);

	// row of MAC cells, one per column of C
	for (genvar g = 0; g < imm_pkg::MAX_DIM; g++) begin : g_cell
		imm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.col_id   (imm_pkg::IDX_W'(g)),
			.bwr      (bwr),
			.feed_in  (chain[g]),
			.feed_out (chain[g+1]),
			.done     (done_vec[g]),
			.acc      (acc_arr[g])
		);
		assign col_mask[g] = imm_pkg::DIM_W'(g) < n_q;
	end

	// pick the one cell that finished this cycle
	always_comb begin
		sel = '0;
		for (int j = 0; j < imm_pkg::MAX_DIM; j++) begin
			if (done_vec[j] && col_mask[j]) begin
				sel = sel | acc_arr[j];
			end
		end
	end

	// only while busy: cells past a smaller column count may still be draining when idle
	assign hit = busy && |(done_vec & col_mask);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		res_d_q <= sel;
	end

	// row and column of the beat on the port
	assign row_wrap = imm_pkg::DIM_W'(out_row_q) + imm_pkg::DIM_W'(1) == m_q;
	assign col_wrap = imm_pkg::DIM_W'(out_col_q) + imm_pkg::DIM_W'(1) == n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (res_v_q) begin
			if (col_wrap) begin
				out_col_q <= '0;
				out_row_q <= row_wrap ? '0 : out_row_q + imm_pkg::IDX_W'(1);
			end else begin
				out_col_q <= out_col_q + imm_pkg::IDX_W'(1);
			end
		end
	end

	assign result_strobe = res_v_q;
	assign c_element     = res_d_q;
	assign row_index     = out_row_q;
	assign col_index     = out_col_q;
	assign last          = res_v_q && row_wrap && col_wrap;

	// checks
	`IMM_NEVER(a_strobe_idle, result_strobe && !busy, "result beat while idle")
	`IMM_ASSERT(a_one_cell, $onehot0(done_vec & col_mask), "two cells finished together")
	`IMM_ASSERT(a_last_idle, last |=> !busy, "busy held after the final beat")
	`IMM_ASSERT(a_idx_start, $rose(busy) |-> (row_index == '0 && col_index == '0), "index not at origin")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the integer matrix multiply: directed and random matrix pairs.
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 200;
	localparam int DRAIN_CYCLES = 8;
	// index 3 is not a register: a write to it must leave the load alone
	localparam logic [imm_pkg::CFG_IDX_W-1:0] REG_SPARE = imm_pkg::CFG_IDX_W'(3);

	// one element of C as it leaves the block
	typedef struct packed {
		logic signed [imm_pkg::ELEM_W-1:0] value;
		logic [imm_pkg::IDX_W-1:0]         row;
		logic [imm_pkg::IDX_W-1:0]         col;
		logic                              last;
	} c_entry_t;

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic signed [imm_pkg::ELEM_W-1:0]  element;
	logic                               busy;
	logic                               cfg_write;
	logic [imm_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [imm_pkg::CFG_DATA_W-1:0]     cfg_data;
	logic                               result_strobe;
	logic signed [imm_pkg::ELEM_W-1:0]  c_element;
	logic [imm_pkg::IDX_W-1:0]          row_index;
	logic [imm_pkg::IDX_W-1:0]          col_index;
	logic                               last;

	// predictor state: matrix stores, sizes and load position
	logic signed [imm_pkg::ELEM_W-1:0] a_mem [imm_pkg::STORE_DEPTH];
	logic signed [imm_pkg::ELEM_W-1:0] b_mem [imm_pkg::STORE_DEPTH];
	int size_rows;
	int size_cols;
	int size_inner;
	int load_count;

	c_entry_t pending_c [$];
	int fail_count;
	int cycle_count;
	int random_sent;
	int burst_left;
	bit steady;

	integer_matrix_multiply dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.element       (element),
		.busy          (busy),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.c_element     (c_element),
		.row_index     (row_index),
		.col_index     (col_index),
		.last          (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// register value to matrix size: 0 means 1, above MAX_DIM means MAX_DIM
	function automatic int size_of(input logic [imm_pkg::CFG_DATA_W-1:0] v);
		int s;
		s = int'(v);
		if (s < 1) begin
			s = 1;
		end else if (s > imm_pkg::MAX_DIM) begin
			s = imm_pkg::MAX_DIM;
		end
		return s;
	endfunction

	// register write as the block sees it; any real register restarts the load
	task automatic apply_reg(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
		input logic [imm_pkg::CFG_DATA_W-1:0] v);
		case (idx)
			imm_pkg::REG_ROW_COUNT: begin
				size_rows = size_of(v);
				load_count = 0;
			end
			imm_pkg::REG_COL_COUNT: begin
				size_cols = size_of(v);
				load_count = 0;
			end
			imm_pkg::REG_INNER_COUNT: begin
				size_inner = size_of(v);
				load_count = 0;
			end
			default: begin
			end
		endcase
	endtask

	// store one accepted element; the final B element yields all of C
	task automatic take_element(input logic signed [imm_pkg::ELEM_W-1:0] value);
		int a_len;
		int total;
		logic [imm_pkg::ELEM_W-1:0] acc;
		c_entry_t r;
		a_len = size_rows * size_inner;
		total = a_len + size_inner * size_cols;
		if (load_count < a_len) begin
			a_mem[load_count] = value;
		end else begin
			b_mem[load_count - a_len] = value;
		end
		load_count++;
		if (load_count < total) begin
			return;
		end
		load_count = 0;
		for (int i = 0; i < size_rows; i++) begin
			for (int j = 0; j < size_cols; j++) begin
				acc = '0;
				// 32-bit context: product and sum wrap like the hardware
				for (int t = 0; t < size_inner; t++) begin
					acc = acc + a_mem[i * size_inner + t] * b_mem[t * size_cols + j];
				end
				r.value = acc;
				r.row = imm_pkg::IDX_W'(i);
				r.col = imm_pkg::IDX_W'(j);
				r.last = (i == size_rows - 1) && (j == size_cols - 1);
				pending_c.push_back(r);
			end
		end
	endtask

	function automatic logic signed [imm_pkg::ELEM_W-1:0] pick_element();
		logic signed [imm_pkg::ELEM_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			2: v = -1;
			3: v = 0;
			4, 5: v = $signed($urandom_range(0, 31)) - 16;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [imm_pkg::CFG_DATA_W-1:0] pick_reg_value();
		if ($urandom_range(0, 4) == 0) begin
			return imm_pkg::CFG_DATA_W'($urandom_range(0, 15));
		end
		return imm_pkg::CFG_DATA_W'($urandom_range(0, 3));
	endfunction

	// one beat on start/element, with random gaps between bursts
	task automatic send_element(input logic signed [imm_pkg::ELEM_W-1:0] value);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		element <= value;
		do @(posedge clk); while (busy);
		take_element(value);
	endtask

	// drop start, wait for all of C and for the block to go quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (pending_c.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [imm_pkg::CFG_IDX_W-1:0] idx,
		input logic [imm_pkg::CFG_DATA_W-1:0] v);
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		apply_reg(idx, v);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// 1x1x1 via zero sizes; products that overflow
	task automatic test_min_size();
		write_reg(imm_pkg::REG_ROW_COUNT, 4'd0);
		write_reg(imm_pkg::REG_COL_COUNT, 4'd1);
		write_reg(imm_pkg::REG_INNER_COUNT, 4'd0);
		send_element(32'h8000_0000);
		send_element(-1);
		send_element(32'h7fff_ffff);
		send_element(32'h7fff_ffff);
		settle();
	endtask

	// spare index keeps the load going; a real register write drops it
	task automatic test_load_restart();
		write_reg(imm_pkg::REG_ROW_COUNT, 4'd1);
		write_reg(imm_pkg::REG_COL_COUNT, 4'd2);
		write_reg(imm_pkg::REG_INNER_COUNT, 4'd2);
		send_element(32'h7fff_ffff);
		send_element(32'h7fff_ffff);
		send_element(1);
		write_reg(REG_SPARE, 4'hf);
		send_element(-1);
		send_element(32'h8000_0000);
		send_element(2);
		settle();
		send_element(5);
		write_reg(imm_pkg::REG_ROW_COUNT, 4'd1);
		repeat (6) send_element(pick_element());
		settle();
	endtask

	// column count above MAX_DIM clamps to a full row of eight
	task automatic test_size_clamp();
		write_reg(imm_pkg::REG_ROW_COUNT, 4'd1);
		write_reg(imm_pkg::REG_INNER_COUNT, 4'd1);
		write_reg(imm_pkg::REG_COL_COUNT, 4'd15);
		repeat (9) send_element(pick_element());
		settle();
	endtask

	// one size setting, an occasional broken load, then whole matrix pairs
	task automatic run_random_phase(input bit largest);
		int pairs;
		int total;
		settle();
		steady = ($urandom_range(0, 3) == 0);
		if (largest) begin
			write_reg(imm_pkg::REG_ROW_COUNT, 4'd8);
			write_reg(imm_pkg::REG_COL_COUNT, 4'd15);
			write_reg(imm_pkg::REG_INNER_COUNT, 4'd8);
		end else begin
			write_reg(imm_pkg::REG_ROW_COUNT, pick_reg_value());
			write_reg(imm_pkg::REG_COL_COUNT, pick_reg_value());
			write_reg(imm_pkg::REG_INNER_COUNT, pick_reg_value());
		end
		if (!largest && $urandom_range(0, 4) == 0) begin
			total = size_rows * size_inner + size_inner * size_cols;
			repeat ($urandom_range(1, total - 1)) begin
				send_element(pick_element());
				random_sent++;
			end
			write_reg(imm_pkg::CFG_IDX_W'($urandom_range(0, 3)), pick_reg_value());
		end
		pairs = largest ? 1 : $urandom_range(1, 3);
		repeat (pairs) begin
			total = size_rows * size_inner + size_inner * size_cols;
			repeat (total) begin
				send_element(pick_element());
				random_sent++;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(1'b1);
		while (random_sent < RANDOM_ITEMS) begin
			run_random_phase(1'b0);
		end
	endtask

	task automatic log_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// compare each result beat with the oldest expected element of C
	always @(posedge clk) begin : check_c
		c_entry_t seen;
		c_entry_t want;
		if (arst_n && result_strobe) begin
			seen = '{c_element, row_index, col_index, last};
			if (pending_c.size() == 0) begin
				log_mismatch($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
					seen.value, seen.row, seen.col, seen.last));
			end else begin
				want = pending_c.pop_front();
				if (seen !== want) begin
					log_mismatch($sformatf(
						"C mismatch: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
						want.value, want.row, want.col, want.last,
						seen.value, seen.row, seen.col, seen.last));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		element = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		size_rows = imm_pkg::MAX_DIM;
		size_cols = imm_pkg::MAX_DIM;
		size_inner = imm_pkg::MAX_DIM;
		load_count = 0;
		fail_count = 0;
		cycle_count = 0;
		random_sent = 0;
		burst_left = 0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_min_size();
		test_load_restart();
		test_size_clamp();
		test_random_traffic();
		settle();
		if (pending_c.size() != 0) begin
			log_mismatch($sformatf("%0d elements of C never arrived", pending_c.size()));
		end
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
